### rtl/core/ztt_pkg.sv
// Shared types and constants for the Zobrist transposition table.
`default_nettype none

package ztt_pkg;

    // Fixed field widths of the stream items
    localparam int MODE_W   = 3;
    localparam int POS_W    = 4;
    localparam int IKEY_W   = 32;
    localparam int CHECK_W  = 64;
    localparam int SCORE_W  = 16;
    localparam int DEPTH_IN_W = 8;
    localparam int KIND_W   = 2;
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 16;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STORE  = 3'd4;

    // Bound kinds of a stored entry
    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd2;

    typedef struct packed {
        logic load_in;     // latch the item, launch both memory reads
        logic commit;      // apply the operation, load the result register
        logic clear_step;  // invalidate one entry of the clearing pass
    } ztt_cmd_t;

    typedef struct packed {
        logic clear_last;  // clearing pass is at its final entry
        logic out_free;    // result register can take a new item
    } ztt_status_t;

endpackage

`default_nettype wire

### rtl/core/ztt_ctrl.sv
// Controller state machine for the Zobrist transposition table.
`default_nettype none

module ztt_ctrl
    import ztt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire ztt_status_t status,
    output ztt_cmd_t         cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register frees up
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ztt_datapath.sv
// Datapath: key store, running keys, entry memory, hit logic and result register.
`default_nettype none

module ztt_datapath
    import ztt_pkg::*;
#(
    parameter int BOARD_SIZE = 15,
    parameter int INDEX_BITS = 12,
    parameter int DEPTH_BITS = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ztt_cmd_t                cmd,
    output ztt_status_t                  status,
    input  wire logic [MODE_W-1:0]       mode,
    input  wire logic                    table_sel,
    input  wire logic [POS_W-1:0]        row,
    input  wire logic [POS_W-1:0]        col,
    input  wire logic                    stone,
    input  wire logic [IKEY_W-1:0]       key_short,
    input  wire logic [CHECK_W-1:0]      key_long,
    input  wire logic signed [SCORE_W-1:0] alpha,
    input  wire logic signed [SCORE_W-1:0] beta,
    input  wire logic [DEPTH_IN_W-1:0]   search_depth,
    input  wire logic signed [SCORE_W-1:0] score,
    input  wire logic [KIND_W-1:0]       bound_kind,
    input  wire logic                    m_tready,
    output logic                         m_tvalid,
    output logic                         hit,
    output logic signed [SCORE_W-1:0]    value
);

    localparam int CELLS       = BOARD_SIZE * BOARD_SIZE;
    localparam int KEY_DEPTH   = 2 * CELLS;
    localparam int CELL_W      = $clog2(KEY_DEPTH);
    localparam int SLOT_W      = INDEX_BITS + 1;
    localparam int ENTRY_DEPTH = 2 << INDEX_BITS;
    localparam int CMP_W       = (DEPTH_BITS > DEPTH_IN_W) ? DEPTH_BITS : DEPTH_IN_W;
    localparam int KIND_LSB    = SCORE_W;
    localparam int DEPTH_LSB   = KIND_LSB + KIND_W;
    localparam int VALID_POS   = DEPTH_LSB + DEPTH_BITS;
    localparam int ENTRY_W     = VALID_POS + 1 + CHECK_W;

    localparam logic [CELL_W-1:0]     CELLS_C   = CELL_W'(CELLS);
    localparam logic [CELL_W-1:0]     BS_C      = CELL_W'(BOARD_SIZE);
    localparam logic [POS_W:0]        BS_CMP    = (POS_W + 1)'(BOARD_SIZE);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    // Accept-side address generation
    logic              pos_ok;
    logic [CELL_W-1:0] cell_in;
    logic [SLOT_W-1:0] slot_in;

    // Captured item
    logic [MODE_W-1:0]         mode_reg;
    logic                      pos_ok_reg;
    logic [CELL_W-1:0]         cell_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [IKEY_W-1:0]         key_short_reg;
    logic [CHECK_W-1:0]        key_long_reg;
    logic signed [SCORE_W-1:0] alpha_reg;
    logic signed [SCORE_W-1:0] beta_reg;
    logic [DEPTH_IN_W-1:0]     want_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [KIND_W-1:0]         kind_reg;

    // Memories and read registers
    logic [CHECK_W+IKEY_W-1:0] key_mem [KEY_DEPTH];
    logic [CHECK_W+IKEY_W-1:0] key_rd_reg;
    logic [ENTRY_W-1:0]        entry_mem [ENTRY_DEPTH];
    logic [ENTRY_W-1:0]        entry_rd_reg;

    logic                      ent_we;
    logic [SLOT_W-1:0]         ent_waddr;
    logic [ENTRY_W-1:0]        ent_wdata;
    logic [DEPTH_BITS-1:0]     depth_sat;
    logic [SLOT_W-1:0]         clr_addr_reg;

    // Running keys
    logic [IKEY_W-1:0]  run_idx_reg;
    logic [IKEY_W-1:0]  run_idx_next;
    logic [CHECK_W-1:0] run_chk_reg;
    logic [CHECK_W-1:0] run_chk_next;

    // Entry fields as read
    logic [CHECK_W-1:0]        rd_chk;
    logic                      rd_valid;
    logic [DEPTH_BITS-1:0]     rd_depth;
    logic [KIND_W-1:0]         rd_kind;
    logic signed [SCORE_W-1:0] rd_score;
    logic                      depth_ok;
    logic                      bound_ok;

    // Result register
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic                      hit_next;
    logic signed [SCORE_W-1:0] value_reg;
    logic signed [SCORE_W-1:0] value_next;

    assign pos_ok  = ({1'b0, row} < BS_CMP) && ({1'b0, col} < BS_CMP);
    assign cell_in = (stone ? CELLS_C : '0) + CELL_W'(row) * BS_C + CELL_W'(col);
    assign slot_in = {table_sel, run_idx_reg[INDEX_BITS-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg      <= mode;
            pos_ok_reg    <= pos_ok;
            cell_reg      <= cell_in;
            slot_reg      <= slot_in;
            key_short_reg <= key_short;
            key_long_reg  <= key_long;
            alpha_reg     <= alpha;
            beta_reg      <= beta;
            want_reg      <= search_depth;
            score_reg     <= score;
            kind_reg      <= bound_kind;
        end
    end

    // Key store: one index key and one check key per stone and cell
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (mode_reg == MODE_LOAD) && pos_ok_reg)
        begin
            key_mem[cell_reg] <= {key_long_reg, key_short_reg};
        end
        if (cmd.load_in && pos_ok)
        begin
            key_rd_reg <= key_mem[cell_in];
        end
    end

    // Saturate the stored depth to the entry field
    assign depth_sat = (CMP_W'(want_reg) > CMP_W'(DEPTH_MAX)) ? DEPTH_MAX
                                                              : DEPTH_BITS'(want_reg);

    assign ent_we    = cmd.clear_step || (cmd.commit && (mode_reg == MODE_STORE));
    assign ent_waddr = cmd.clear_step ? clr_addr_reg : slot_reg;
    assign ent_wdata = cmd.clear_step ? '0
                                      : {run_chk_reg, 1'b1, depth_sat, kind_reg, score_reg};

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        if (cmd.load_in)
        begin
            entry_rd_reg <= entry_mem[slot_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign rd_chk   = entry_rd_reg[ENTRY_W-1 -: CHECK_W];
    assign rd_valid = entry_rd_reg[VALID_POS];
    assign rd_depth = entry_rd_reg[DEPTH_LSB +: DEPTH_BITS];
    assign rd_kind  = entry_rd_reg[KIND_LSB +: KIND_W];
    assign rd_score = $signed(entry_rd_reg[SCORE_W-1:0]);
    assign depth_ok = CMP_W'(rd_depth) >= CMP_W'(want_reg);

    always_comb
    begin
        case (rd_kind)
            KIND_EXACT: bound_ok = 1'b1;
            KIND_LOWER: bound_ok = rd_score >= beta_reg;
            KIND_UPPER: bound_ok = rd_score <= alpha_reg;
            default:    bound_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        run_idx_next = run_idx_reg;
        run_chk_next = run_chk_reg;
        hit_next     = 1'b0;
        value_next   = '0;
        unique case (mode_reg)
            MODE_CLEAR:
            begin
                run_idx_next = '0;
                run_chk_next = '0;
            end
            MODE_TOGGLE:
            begin
                if (pos_ok_reg)
                begin
                    run_idx_next = run_idx_reg ^ key_rd_reg[IKEY_W-1:0];
                    run_chk_next = run_chk_reg ^ key_rd_reg[CHECK_W+IKEY_W-1:IKEY_W];
                end
            end
            MODE_LOOKUP:
            begin
                if (rd_valid && depth_ok && (rd_chk == run_chk_reg) && bound_ok)
                begin
                    hit_next   = 1'b1;
                    value_next = rd_score;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_idx_reg   <= '0;
            run_chk_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                run_idx_reg   <= run_idx_next;
                run_chk_reg   <= run_chk_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg   <= hit_next;
            value_reg <= value_next;
        end
    end

    assign status.clear_last = &clr_addr_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign hit      = hit_reg;
    assign value    = value_reg;

endmodule

`default_nettype wire

### rtl/core/zobrist_transposition_table.sv
// Top level of the Zobrist-keyed transposition table.
//
//  channel | dir | tuser         | tdata
//  --------+-----+---------------+------------------------------------------------
//  s_*     | in  | mode [2:0]    | table_sel .. bound_kind, 164 bits packed in 168
//  m_*     | out | hit [0]       | value [15:0]
//
// For each item, the accept edge reads the key store and the entry memory; once the
// result register is free, a later edge applies the operation and loads the result
// register. One item is in work at a time, and the next is taken while the result
// register still waits. After reset the entry memory runs a clearing pass over all
// 2 << INDEX_BITS entries (8192 at the defaults) with s_tready low. A stalled m_*
// side holds the item in work until the result register frees up.
`default_nettype none

module zobrist_transposition_table
    import ztt_pkg::*;
#(
    parameter int BOARD_SIZE = 15,
    parameter int INDEX_BITS = 12,
    parameter int DEPTH_BITS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // bits from 0: table_sel, row[4], col[4], stone, key_short[32], key_long[64],
    // alpha[16], beta[16], search_depth[8], score[16], bound_kind[2], zero pad[4]
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // bits from 0: mode[3]
    input  wire logic [MODE_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // bits from 0: value[16]
    output logic [M_DATA_W-1:0]        m_tdata,
    // bits from 0: hit
    output logic                       m_tuser
);

    ztt_cmd_t                  cmd;
    ztt_status_t               status;
    logic signed [SCORE_W-1:0] value;

    // Controller: clearing pass, accept, commit when the output side is free
    ztt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: unpack the item fields straight from the slave bus
    ztt_datapath
    #(
        .BOARD_SIZE (BOARD_SIZE),
        .INDEX_BITS (INDEX_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (s_tuser),
        .table_sel    (s_tdata[0]),
        .row          (s_tdata[4:1]),
        .col          (s_tdata[8:5]),
        .stone        (s_tdata[9]),
        .key_short    (s_tdata[41:10]),
        .key_long     (s_tdata[105:42]),
        .alpha        ($signed(s_tdata[121:106])),
        .beta         ($signed(s_tdata[137:122])),
        .search_depth (s_tdata[145:138]),
        .score        ($signed(s_tdata[161:146])),
        .bound_kind   (s_tdata[163:162]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .hit          (m_tuser),
        .value        (value)
    );

    assign m_tdata = value;

endmodule

`default_nettype wire

### rtl/core/ztt_checker.sv
// Port-level checker for the transposition table, bound to the top level.
`default_nettype none

module ztt_checker
    import ztt_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tuser
);

    // Hold a stalled result steady
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A miss reports a zero value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero value");

    // One item in work: ready drops right after an accept
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in work");

    // A fresh result follows a matching earlier accept
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching item");

endmodule

bind zobrist_transposition_table ztt_checker u_ztt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking stream testbench for the Zobrist transposition table.
`default_nettype none

module tb_top;
    import ztt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOARD      = 15;
    localparam int IDX_BITS   = 12;
    localparam int DEP_BITS   = 8;
    localparam int CELLS      = BOARD * BOARD;
    localparam int NUM_KEYS   = 2 * CELLS;
    localparam int NUM_SLOTS  = 2 << IDX_BITS;

    // Spare operation codes; the block must treat them as no-ops
    localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
    // Bound kind that is stored as given but never yields a hit
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic               tsel;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic               stone;
        logic [IKEY_W-1:0]  key_short;
        logic [CHECK_W-1:0] key_long;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [KIND_W-1:0]  kind;
    } tt_op_t;

    typedef struct {
        logic        hit;
        logic [15:0] value;
    } probe_result_t;

    typedef struct {
        tt_op_t      op;
        bit          known;
        logic        hit;
        logic [15:0] value;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // table_sel, row, col, stone, keys, window, depth, ...
    logic [MODE_W-1:0]   s_tuser;   // mode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;   // value
    logic                m_tuser;   // hit

    // Predictor state: key store, running hashes and both tables
    logic [IKEY_W-1:0]   zkey_index [NUM_KEYS];
    logic [CHECK_W-1:0]  zkey_check [NUM_KEYS];
    bit                  cell_loaded [NUM_KEYS];
    int                  loaded_cells [$];
    logic [IKEY_W-1:0]   hash_index;
    logic [CHECK_W-1:0]  hash_check;
    logic [CHECK_W-1:0]  slot_check [NUM_SLOTS];
    bit                  slot_valid [NUM_SLOTS];
    logic [7:0]          slot_depth [NUM_SLOTS];
    logic [KIND_W-1:0]   slot_kind  [NUM_SLOTS];
    logic signed [15:0]  slot_score [NUM_SLOTS];

    // Stones toggled since the last clear, so random play can unmake moves
    int                  move_trail [$];
    probe_result_t       probe_results_q [$];
    int                  mismatches = 0;
    int                  snd_idle_pct = 21;
    int                  rcv_idle_pct = 67;

    zobrist_transposition_table #(
        .BOARD_SIZE (BOARD),
        .INDEX_BITS (IDX_BITS),
        .DEPTH_BITS (DEP_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run (clearing pass included)
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Stall the result side at random, once per cycle
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);

    // Compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        probe_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (probe_results_q.size() == 0)
            begin
                $error("unexpected result: hit %0b value %0h", m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                exp_res = probe_results_q.pop_front();
                if (m_tuser !== exp_res.hit)
                begin
                    $error("hit: expected %0b, got %0b", exp_res.hit, m_tuser);
                    mismatches++;
                end
                if (m_tdata !== exp_res.value)
                begin
                    $error("value: expected %0h, got %0h", exp_res.value, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Advance the predictor by one accepted item and return its result
    task automatic predict_probe(input tt_op_t op, output probe_result_t res);
        int  slot;
        int  key_pos;
        bit  on_board;
        bit  usable;
        slot     = int'({op.tsel, hash_index[IDX_BITS-1:0]});
        on_board = (int'(op.row) < BOARD) && (int'(op.col) < BOARD);
        key_pos  = int'(op.stone) * CELLS + int'(op.row) * BOARD + int'(op.col);
        usable   = 1'b0;
        res.hit   = 1'b0;
        res.value = '0;
        case (op.mode)
            MODE_LOAD:
                if (on_board)
                begin
                    zkey_index[key_pos] = op.key_short;
                    zkey_check[key_pos] = op.key_long;
                    if (!cell_loaded[key_pos])
                        loaded_cells.push_back(key_pos);
                    cell_loaded[key_pos] = 1'b1;
                end
            MODE_CLEAR:
            begin
                hash_index = '0;
                hash_check = '0;
            end
            MODE_TOGGLE:
                if (on_board)
                begin
                    hash_index ^= zkey_index[key_pos];
                    hash_check ^= zkey_check[key_pos];
                end
            MODE_LOOKUP:
            begin
                if (slot_valid[slot] && slot_depth[slot] >= op.depth
                    && slot_check[slot] == hash_check)
                begin
                    case (slot_kind[slot])
                        KIND_EXACT: usable = 1'b1;
                        KIND_LOWER: usable = slot_score[slot] >= op.beta;
                        KIND_UPPER: usable = slot_score[slot] <= op.alpha;
                        default:    usable = 1'b0;
                    endcase
                end
                if (usable)
                begin
                    res.hit   = 1'b1;
                    res.value = slot_score[slot];
                end
            end
            MODE_STORE:
            begin
                // Stored depth is as wide as the asked depth, so no saturation occurs
                slot_check[slot] = hash_check;
                slot_valid[slot] = 1'b1;
                slot_depth[slot] = op.depth;
                slot_kind[slot]  = op.kind;
                slot_score[slot] = op.score;
            end
            default: ;
        endcase
    endtask

    // Present one item, hold it until accepted, then log its expected result
    task automatic send_op(input tt_op_t op, input bit known, input logic k_hit,
                           input logic [15:0] k_value);
        probe_result_t res;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.mode;
        s_tdata  <= {4'b0, op.kind, op.score, op.depth, op.beta, op.alpha,
                     op.key_long, op.key_short, op.stone, op.col, op.row, op.tsel};
        do
            @(posedge clk);
        while (!s_tready);
        predict_probe(op, res);
        if (known)
        begin
            res.hit   = k_hit;
            res.value = k_value;
        end
        probe_results_q.push_back(res);
        @(negedge clk);
    endtask

    // Hold off until every outstanding result has drained
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (probe_results_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic stim_row_t dir_row(logic [MODE_W-1:0] m, int t, int s, int r, int c,
                                          logic [31:0] ks, logic [63:0] kl,
                                          int a, int b, int d, int sc,
                                          logic [KIND_W-1:0] k,
                                          int known, int h, int v);
        stim_row_t rw;
        rw.op.mode      = m;
        rw.op.tsel      = 1'(t);
        rw.op.stone     = 1'(s);
        rw.op.row       = POS_W'(r);
        rw.op.col       = POS_W'(c);
        rw.op.key_short = ks;
        rw.op.key_long  = kl;
        rw.op.alpha     = 16'(a);
        rw.op.beta      = 16'(b);
        rw.op.depth     = 8'(d);
        rw.op.score     = 16'(sc);
        rw.op.kind      = k;
        rw.known        = 1'(known);
        rw.hit          = 1'(h);
        rw.value        = 16'(v);
        return rw;
    endfunction

    function automatic logic signed [15:0] rand_s16();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Draw one random item; mostly legal play with random content, some noise
    function automatic tt_op_t next_random_op();
        tt_op_t op;
        int     roll;
        int     key_pos;
        int     slot;
        op.mode      = MODE_SPARE5;
        op.tsel      = 1'($urandom);
        op.row       = POS_W'($urandom);
        op.col       = POS_W'($urandom);
        op.stone     = 1'($urandom);
        op.key_short = $urandom;
        op.key_long  = {$urandom, $urandom};
        op.alpha     = rand_s16();
        op.beta      = rand_s16();
        op.depth     = 8'($urandom);
        op.score     = rand_s16();
        op.kind      = ($urandom_range(9) == 0) ? KIND_NONE : KIND_W'($urandom_range(2));
        roll = $urandom_range(99);
        if (roll < 6)
        begin
            op.mode = MODE_LOAD;
            if ($urandom_range(99) < 85)
            begin
                key_pos  = $urandom_range(NUM_KEYS - 1);
                op.stone = 1'(key_pos / CELLS);
                op.row   = POS_W'((key_pos % CELLS) / BOARD);
                op.col   = POS_W'(key_pos % BOARD);
            end
            else if ($urandom_range(1))
                op.row = POS_W'(BOARD);
            else
                op.col = POS_W'(BOARD);
        end
        else if (roll < 10)
        begin
            op.mode = MODE_CLEAR;
            move_trail.delete();
        end
        else if (roll < 42)
        begin
            op.mode = MODE_TOGGLE;
            if ($urandom_range(99) < 10)
            begin
                // off the board: reads no key
                op.row = POS_W'(BOARD + $urandom_range(0, 15 - BOARD));
            end
            else
            begin
                if (move_trail.size() != 0 && $urandom_range(99) < 35)
                    key_pos = move_trail.pop_back();
                else
                begin
                    key_pos = loaded_cells[$urandom_range(loaded_cells.size() - 1)];
                    move_trail.push_back(key_pos);
                end
                op.stone = 1'(key_pos / CELLS);
                op.row   = POS_W'((key_pos % CELLS) / BOARD);
                op.col   = POS_W'(key_pos % BOARD);
            end
        end
        else if (roll < 64)
            op.mode = MODE_STORE;
        else if (roll < 94)
        begin
            // look up only slots that were stored; fall back to a store otherwise
            op.mode = MODE_LOOKUP;
            slot = int'({op.tsel, hash_index[IDX_BITS-1:0]});
            if (!slot_valid[slot])
            begin
                op.tsel = ~op.tsel;
                slot    = int'({op.tsel, hash_index[IDX_BITS-1:0]});
            end
            if (!slot_valid[slot])
                op.mode = MODE_STORE;
            else
            begin
                if ($urandom_range(99) < 70)
                    op.depth = 8'($urandom_range(slot_depth[slot]));
                case ($urandom_range(3))
                    0: op.alpha = slot_score[slot];
                    1: op.beta  = slot_score[slot];
                    default: ;
                endcase
            end
        end
        else
            op.mode = MODE_W'(MODE_SPARE5 + $urandom_range(2));
        return op;
    endfunction

    initial
    begin
        stim_row_t directed_rows [];
        int        phase;
        int        n;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = MODE_CLEAR;
        hash_index = '0;
        hash_check = '0;
        foreach (zkey_index[i])
        begin
            zkey_index[i]  = '0;
            zkey_check[i]  = '0;
            cell_loaded[i] = 1'b0;
        end
        foreach (slot_valid[i])
        begin
            slot_valid[i] = 1'b0;
            slot_check[i] = '0;
            slot_depth[i] = '0;
            slot_kind[i]  = KIND_EXACT;
            slot_score[i] = '0;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Index key of the far corner has zero low bits, so both toggled stones
        // and the first stone alone land on the same slot with different checksums.
        directed_rows = '{
            dir_row(MODE_LOAD,   0, 0,  0,  0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    0, 0, 0, 0, KIND_EXACT, 1, 0, 0),
            dir_row(MODE_LOAD,   1, 1, 14, 14, 32'h1234_5000, 64'h0123_4567_89AB_CDEF,
                    0, 0, 0, 0, KIND_EXACT, 1, 0, 0),
            // position off the board: load does nothing
            dir_row(MODE_LOAD,   0, 0, 15,  3, 32'h0000_0000, 64'h0,
                    0, 0, 0, 0, KIND_EXACT, 1, 0, 0),
            dir_row(MODE_LOAD,   1, 1,  7, 15, 32'hDEAD_BEEF, 64'hFEDC_BA98_7654_3210,
                    -1, -1, 255, -1, KIND_NONE, 1, 0, 0),
            dir_row(MODE_TOGGLE, 0, 0,  0,  0, 32'h0, 64'h0,
                    0, 0, 0, 0, KIND_EXACT, 1, 0, 0),
            dir_row(MODE_TOGGLE, 0, 1, 14, 14, 32'h0, 64'h0,
                    0, 0, 0, 0, KIND_EXACT, 1, 0, 0),
            dir_row(MODE_TOGGLE, 1, 0, 15, 15, 32'h0, 64'h0,
                    0, 0, 0, 0, KIND_EXACT, 1, 0, 0),
            dir_row(MODE_STORE,  0, 0,  0,  0, 32'h0, 64'h0,
                    0, 0, 255, 32767, KIND_EXACT, 1, 0, 0),
            dir_row(MODE_LOOKUP, 0, 0,  0,  0, 32'h0, 64'h0,
                    -32768, 32767, 255, 0, KIND_EXACT, 1, 1, 'h7FFF),
            dir_row(MODE_LOOKUP, 0, 0,  0,  0, 32'h0, 64'h0,
                    0, 0, 0, 0, KIND_EXACT, 0, 0, 0),
            dir_row(MODE_STORE,  1, 0,  0,  0, 32'h0, 64'h0,
                    0, 0, 0, -32768, KIND_LOWER, 1, 0, 0),
            dir_row(MODE_LOOKUP, 1, 0,  0,  0, 32'h0, 64'h0,
                    0, -32768, 0, 0, KIND_EXACT, 1, 1, 'h8000),
            dir_row(MODE_LOOKUP, 1, 0,  0,  0, 32'h0, 64'h0,
                    0, -32768, 1, 0, KIND_EXACT, 0, 0, 0),
            dir_row(MODE_LOOKUP, 1, 0,  0,  0, 32'h0, 64'h0,
                    0, 32767, 0, 0, KIND_EXACT, 0, 0, 0),
            dir_row(MODE_STORE,  1, 0,  0,  0, 32'h0, 64'h0,
                    0, 0, 10, 100, KIND_UPPER, 0, 0, 0),
            dir_row(MODE_LOOKUP, 1, 0,  0,  0, 32'h0, 64'h0,
                    100, 0, 10, 0, KIND_EXACT, 0, 0, 0),
            dir_row(MODE_LOOKUP, 1, 0,  0,  0, 32'h0, 64'h0,
                    99, 0, 10, 0, KIND_EXACT, 0, 0, 0),
            // bound kind 3 is kept but never hits
            dir_row(MODE_STORE,  0, 0,  0,  0, 32'h0, 64'h0,
                    0, 0, 200, -1, KIND_NONE, 1, 0, 0),
            dir_row(MODE_LOOKUP, 0, 0,  0,  0, 32'h0, 64'h0,
                    32767, -32768, 0, 0, KIND_EXACT, 1, 0, 0),
            dir_row(MODE_SPARE5, 1, 1, 15, 15, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    -1, -1, 255, -1, KIND_NONE, 1, 0, 0),
            dir_row(MODE_SPARE6, 0, 0,  0,  0, 32'h0, 64'h0,
                    0, 0, 0, 0, KIND_EXACT, 1, 0, 0),
            dir_row(MODE_SPARE7, 1, 1,  3,  9, 32'h5555_AAAA, 64'hAAAA_5555_AAAA_5555,
                    1, 2, 3, 4, KIND_LOWER, 1, 0, 0),
            dir_row(MODE_CLEAR,  0, 0,  0,  0, 32'h0, 64'h0,
                    0, 0, 0, 0, KIND_EXACT, 1, 0, 0),
            dir_row(MODE_TOGGLE, 0, 0,  0,  0, 32'h0, 64'h0,
                    0, 0, 0, 0, KIND_EXACT, 1, 0, 0),
            // same slot, checksum differs: miss
            dir_row(MODE_LOOKUP, 1, 0,  0,  0, 32'h0, 64'h0,
                    32767, 0, 0, 0, KIND_EXACT, 1, 0, 0)
        };

        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].known,
                    directed_rows[i].hit, directed_rows[i].value);

        // Three idling profiles; drain fully between them
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    snd_idle_pct = 21;
                    rcv_idle_pct = 67;
                end
                1:
                begin
                    snd_idle_pct = 67;
                    rcv_idle_pct = 21;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < 215; n++)
                send_op(next_random_op(), 1'b0, 1'b0, '0);
            drain_results();
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0 && probe_results_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/core/ztt_pkg.sv
rtl/core/ztt_ctrl.sv
rtl/core/ztt_datapath.sv
rtl/core/zobrist_transposition_table.sv
rtl/core/ztt_checker.sv
tb/tb_top.sv
